>>> design/smx_pkg.sv
// ---------------------------------------------------------------------------
// smx_pkg: shared types and constants of the softmax vector engine
// Holds the fixed-point widths, the exponential lookup table built at
// elaboration, the control state encoding and the store control struct.
// ---------------------------------------------------------------------------
package smx_pkg;

  localparam int unsigned ScoreW = 8;
  localparam int unsigned ExpW   = 28;
  localparam int unsigned SumW   = 34;
  localparam int unsigned ProbW  = 16;
  localparam int unsigned LutLen = 256;

  typedef logic [ExpW-1:0] exp_t;
  typedef logic [SumW-1:0] sum_t;
  typedef logic [ProbW-1:0] prob_t;
  typedef exp_t exp_lut_t [LutLen];

  typedef enum logic [2:0] {
    ST_COLLECT,
    ST_READ,
    ST_LOAD,
    ST_DIV,
    ST_WAIT
  } smx_state_e;

  typedef struct packed {
    logic push;
    logic clear;
    logic rd_en;
  } smx_store_ctrl_t;

  // Taylor terms of exp(1/16) in Q2.62; each term is the previous one
  // over 16 * n, truncated at every step.
  localparam logic [63:0] TaylorT0  = 64'd1 << 62;
  localparam logic [63:0] TaylorT1  = TaylorT0  / 64'd16;
  localparam logic [63:0] TaylorT2  = TaylorT1  / 64'd32;
  localparam logic [63:0] TaylorT3  = TaylorT2  / 64'd48;
  localparam logic [63:0] TaylorT4  = TaylorT3  / 64'd64;
  localparam logic [63:0] TaylorT5  = TaylorT4  / 64'd80;
  localparam logic [63:0] TaylorT6  = TaylorT5  / 64'd96;
  localparam logic [63:0] TaylorT7  = TaylorT6  / 64'd112;
  localparam logic [63:0] TaylorT8  = TaylorT7  / 64'd128;
  localparam logic [63:0] TaylorT9  = TaylorT8  / 64'd144;
  localparam logic [63:0] TaylorT10 = TaylorT9  / 64'd160;
  localparam logic [63:0] TaylorT11 = TaylorT10 / 64'd176;
  localparam logic [63:0] TaylorT12 = TaylorT11 / 64'd192;
  localparam logic [63:0] TaylorT13 = TaylorT12 / 64'd208;
  localparam logic [63:0] TaylorT14 = TaylorT13 / 64'd224;
  localparam logic [63:0] TaylorT15 = TaylorT14 / 64'd240;
  localparam logic [63:0] TaylorT16 = TaylorT15 / 64'd256;
  localparam logic [63:0] TaylorT17 = TaylorT16 / 64'd272;
  localparam logic [63:0] TaylorT18 = TaylorT17 / 64'd288;
  localparam logic [63:0] TaylorT19 = TaylorT18 / 64'd304;
  localparam logic [63:0] TaylorT20 = TaylorT19 / 64'd320;

  // exp(+1/16) and exp(-1/16) in Q2.62; the odd terms change sign for the
  // negative step.
  localparam logic [63:0] ExpUpQ62 = TaylorT0 + TaylorT1 + TaylorT2 + TaylorT3 +
                                     TaylorT4 + TaylorT5 + TaylorT6 + TaylorT7 +
                                     TaylorT8 + TaylorT9 + TaylorT10 + TaylorT11 +
                                     TaylorT12 + TaylorT13 + TaylorT14 + TaylorT15 +
                                     TaylorT16 + TaylorT17 + TaylorT18 + TaylorT19 +
                                     TaylorT20;
  localparam logic [63:0] ExpDnQ62 = TaylorT0 - TaylorT1 + TaylorT2 - TaylorT3 +
                                     TaylorT4 - TaylorT5 + TaylorT6 - TaylorT7 +
                                     TaylorT8 - TaylorT9 + TaylorT10 - TaylorT11 +
                                     TaylorT12 - TaylorT13 + TaylorT14 - TaylorT15 +
                                     TaylorT16 - TaylorT17 + TaylorT18 - TaylorT19 +
                                     TaylorT20;

  // Product of a Q12.52 value and a Q2.62 factor, kept in Q12.52.
  function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] prod;
    prod = {64'd0, a} * {64'd0, b};
    return prod[125:62];
  endfunction

  // Q12.52 rounded to a Q.16 table entry.
  function automatic exp_t round_q52(input logic [63:0] p);
    logic [63:0] r;
    r = (p + (64'd1 << 35)) >> 36;
    return r[ExpW-1:0];
  endfunction

  // Table of round(exp(x/16) * 65536), indexed by score + 128.
  function automatic exp_lut_t build_exp_lut();
    exp_lut_t    lut;
    logic [63:0] up;
    logic [63:0] down;
    logic [63:0] p;
    up   = ExpUpQ62;
    down = ExpDnQ62;
    p    = 64'd1 << 52;
    lut[128] = round_q52(p);
    for (int k = 1; k <= 127; k++) begin
      p = mul_q62(p, up);
      lut[128 + k] = round_q52(p);
    end
    p = 64'd1 << 52;
    for (int k = 1; k <= 128; k++) begin
      p = mul_q62(p, down);
      lut[128 - k] = round_q52(p);
    end
    return lut;
  endfunction

  localparam exp_lut_t ExpLut = build_exp_lut();

endpackage

>>> design/smx_store.sv
// ---------------------------------------------------------------------------
// smx_store: exponential lookup, element store and running sum
// Maps each accepted score through the exponential table, writes the value
// into the element memory and adds it to the vector sum.
// ---------------------------------------------------------------------------
module smx_store import smx_pkg::*; #(
  parameter int unsigned MAX_LEN = 64,
  parameter int unsigned AW      = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1,
  parameter int unsigned CW      = $clog2(MAX_LEN + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  smx_store_ctrl_t   ctrl_i,
  input  logic [ScoreW-1:0] score_i,
  input  logic [AW-1:0]     rd_addr_i,
  output exp_t              rd_data_o,
  output sum_t              sum_o,
  output logic [CW-1:0]     count_o,
  output logic              dropped_o
);

  exp_t          mem [MAX_LEN];
  exp_t          rd_data_q;
  sum_t          sum_q, sum_d;
  logic [CW-1:0] count_q, count_d;
  logic          dropped_q, dropped_d;
  exp_t          exp_val;
  logic          room;
  logic [7:0]    lut_idx;

  // Flipping the sign bit turns the signed score into score + 128.
  assign lut_idx = {~score_i[ScoreW-1], score_i[ScoreW-2:0]};
  assign exp_val = ExpLut[lut_idx];
  assign room    = (count_q < CW'(MAX_LEN));

  always_comb begin
    sum_d     = sum_q;
    count_d   = count_q;
    dropped_d = dropped_q;
    if (ctrl_i.clear) begin
      sum_d     = '0;
      count_d   = '0;
      dropped_d = 1'b0;
    end else if (ctrl_i.push) begin
      if (room) begin
        sum_d   = sum_q + SumW'(exp_val);
        count_d = count_q + CW'(1);
      end else begin
        dropped_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q     <= '0;
      count_q   <= '0;
      dropped_q <= 1'b0;
    end else begin
      sum_q     <= sum_d;
      count_q   <= count_d;
      dropped_q <= dropped_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.push && room) begin
      mem[count_q[AW-1:0]] <= exp_val;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.rd_en) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;
  assign sum_o     = sum_q;
  assign count_o   = count_q;
  assign dropped_o = dropped_q;

endmodule

>>> design/smx_div.sv
// ---------------------------------------------------------------------------
// smx_div: serial restoring divider
// Produces the saturated Q0.16 quotient of an element over the sum, one
// quotient bit per cycle through a shifting remainder register.
// ---------------------------------------------------------------------------
module smx_div import smx_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start_i,
  input  exp_t  dividend_i,
  input  sum_t  divisor_i,
  output prob_t quotient_o,
  output logic  done_o
);

  localparam int unsigned CntW = $clog2(ProbW + 1);

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [SumW:0]   rem_q, rem_d;
  sum_t            div_q, div_d;
  prob_t           quo_q, quo_d;
  logic [SumW:0]   rem_sh;
  logic            fits;
  logic            saturate;

  // The quotient reaches 65536 or more exactly when the element is not
  // below the sum; an empty sum also gives the saturated value.
  assign saturate = (divisor_i == '0) || (SumW'(dividend_i) >= divisor_i);
  assign rem_sh   = {rem_q[SumW-1:0], 1'b0};
  assign fits     = (rem_sh >= {1'b0, div_q});

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    div_d  = div_q;
    quo_d  = quo_q;
    if (start_i) begin
      div_d = divisor_i;
      rem_d = (SumW + 1)'(dividend_i);
      quo_d = '0;
      if (saturate) begin
        quo_d  = '1;
        done_d = 1'b1;
      end else begin
        busy_d = 1'b1;
        cnt_d  = CntW'(ProbW);
      end
    end else if (busy_q) begin
      rem_d = fits ? (rem_sh - {1'b0, div_q}) : rem_sh;
      quo_d = {quo_q[ProbW-2:0], fits};
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    div_q <= div_d;
    quo_q <= quo_d;
  end

  assign quotient_o = quo_q;
  assign done_o     = done_q;

endmodule

>>> design/softmax_vector_engine.sv
// ---------------------------------------------------------------------------
// softmax_vector_engine: fixed-point softmax over a vector of scores
// Collects Q4.4 scores, then streams one saturated Q0.16 probability per
// held element in arrival order.
// ---------------------------------------------------------------------------
// Scores are taken one per cycle while the engine collects a vector: each
// one is turned into round(exp(x) * 65536) by a 256-entry table, written to
// an element memory of MAX_LEN entries and added to a 34-bit running sum.
// Scores beyond MAX_LEN are not stored, and every result of that vector then
// carries the overflowed flag. The request marked final_element starts the
// output phase, during which no scores are taken. Each result passes through
// the memory read, the divider start, one quotient step per quotient bit of
// the bit-serial restoring divider, its done flag and the hand-over of the
// quotient to the output register once that register is free. A result that
// saturates skips the quotient steps. The output register lets the next
// result be computed while the previous one waits to be taken, and the last
// result is marked by last_result. New scores are accepted as soon as the
// last result has been loaded into the output register.
module softmax_vector_engine import smx_pkg::*; #(
  parameter int unsigned MAX_LEN = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [ScoreW-1:0] score_i,
  input  logic              final_element_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [ProbW-1:0]  probability_o,
  output logic              last_result_o,
  output logic              overflowed_o
);

  localparam int unsigned AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int unsigned CW = $clog2(MAX_LEN + 1);

  smx_state_e      state_q, state_d;
  logic [CW-1:0]   idx_q, idx_d;
  smx_store_ctrl_t store_ctrl;
  exp_t            rd_data;
  sum_t            exp_sum;
  logic [CW-1:0]   count;
  logic            dropped;
  logic            div_start;
  logic            div_done;
  prob_t           quotient;
  logic            out_free;
  logic            out_load;
  logic            is_last;

  logic            out_valid_q;
  prob_t           prob_q;
  logic            last_q;
  logic            ovf_q;

  smx_store #(
    .MAX_LEN (MAX_LEN),
    .AW      (AW),
    .CW      (CW)
  ) u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (store_ctrl),
    .score_i   (score_i),
    .rd_addr_i (idx_q[AW-1:0]),
    .rd_data_o (rd_data),
    .sum_o     (exp_sum),
    .count_o   (count),
    .dropped_o (dropped)
  );

  smx_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (rd_data),
    .divisor_i  (exp_sum),
    .quotient_o (quotient),
    .done_o     (div_done)
  );

  assign out_free = !out_valid_q || out_ready_i;
  assign is_last  = ((idx_q + CW'(1)) == count);

  // Sequencer: collect the vector, then walk the stored elements one at a
  // time through the divider. The sum is cleared only after the last result
  // has left the divider.
  always_comb begin
    state_d          = state_q;
    idx_d            = idx_q;
    in_ready_o       = 1'b0;
    store_ctrl.push  = 1'b0;
    store_ctrl.clear = 1'b0;
    store_ctrl.rd_en = 1'b0;
    div_start        = 1'b0;
    out_load         = 1'b0;
    unique case (state_q)
      ST_COLLECT: begin
        in_ready_o      = 1'b1;
        store_ctrl.push = in_valid_i;
        if (in_valid_i && final_element_i) begin
          idx_d   = '0;
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        store_ctrl.rd_en = 1'b1;
        state_d          = ST_LOAD;
      end
      ST_LOAD: begin
        div_start = 1'b1;
        state_d   = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          state_d = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (out_free) begin
          out_load = 1'b1;
          if (is_last) begin
            store_ctrl.clear = 1'b1;
            state_d          = ST_COLLECT;
          end else begin
            idx_d   = idx_q + CW'(1);
            state_d = ST_READ;
          end
        end
      end
      default: begin
        state_d = ST_COLLECT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_COLLECT;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      prob_q <= quotient;
      last_q <= is_last;
      ovf_q  <= dropped;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign probability_o = prob_q;
  assign last_result_o = last_q;
  assign overflowed_o  = ovf_q;

endmodule

>>> sim/tb_softmax_vector_engine.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_softmax_vector_engine: self-checking bench of the softmax vector engine
// Streams vectors of Q4.4 scores into the engine, predicts every Q0.16
// probability with an independent exponential table and divider, and
// compares each result field by field while both sides stall at random.
// ---------------------------------------------------------------------------
module tb_softmax_vector_engine;
  import smx_pkg::*;

  localparam int HeldMax     = 64;    // capacity of the engine's element memory
  localparam int ItemTarget  = 350;   // random and directed requests together
  localparam int TailLen     = 40;    // last requests run without idling
  localparam int DrainCycles = 100;   // idle cycles after the last expected result

  typedef struct {
    logic [ScoreW-1:0] score;
    logic              fin;
    int                gap;     // idle cycles before this request
    bit                drain;   // wait for every pending result first
  } score_req_t;

  typedef struct packed {
    prob_t probability;
    logic  last_result;
    logic  overflowed;
  } softmax_out_t;

  logic              clk_i           = 1'b0;
  logic              rst_ni          = 1'b0;
  logic              in_valid        = 1'b0;
  logic              in_ready;
  logic [ScoreW-1:0] score           = '0;
  logic              final_element   = 1'b0;
  logic              out_valid;
  logic              out_ready       = 1'b0;
  prob_t             probability;
  logic              last_result;
  logic              overflowed;

  // Predictor state: the exponential table and the vector being collected.
  logic [27:0]  exp_rom [256];
  logic [27:0]  held_e [HeldMax];
  logic [33:0]  held_sum;
  int           held_cnt;
  logic         dropped;

  score_req_t   queued_scores[$];
  softmax_out_t due_probs[$];
  int           total_reqs;
  int           accepted_cnt;
  int           err_cnt;

  always #5 clk_i = ~clk_i;

  softmax_vector_engine #(
    .MAX_LEN(HeldMax)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .score_i        (score),
    .final_element_i(final_element),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .probability_o  (probability),
    .last_result_o  (last_result),
    .overflowed_o   (overflowed)
  );

  // exp(+1/16) or exp(-1/16) in Q2.62, summed from twenty-one Taylor terms.
  function automatic logic [63:0] sixteenth_exp(input bit neg);
    logic [63:0] t;
    logic [63:0] s;
    t = 64'd1 << 62;
    s = t;
    for (int n = 1; n <= 20; n++) begin
      t = t / (64'd16 * 64'(n));
      s = (neg && (n % 2 == 1)) ? s - t : s + t;
    end
    return s;
  endfunction

  // Rounds a Q12.52 value to the Q.16 table format.
  function automatic logic [27:0] q52_to_q16(input logic [63:0] p);
    logic [63:0] r;
    r = (p + (64'd1 << 35)) >> 36;
    return r[27:0];
  endfunction

  // Builds round(exp(x/16) * 65536) for every score, index = score + 128,
  // by walking powers of exp(1/16) upward and of exp(-1/16) downward.
  task automatic fill_exp_rom();
    logic [63:0]  f_up;
    logic [63:0]  f_dn;
    logic [63:0]  pu;
    logic [63:0]  pd;
    logic [127:0] prod;
    f_up = sixteenth_exp(1'b0);
    f_dn = sixteenth_exp(1'b1);
    pu = 64'd1 << 52;
    pd = pu;
    exp_rom[128] = q52_to_q16(pu);
    for (int k = 1; k <= 128; k++) begin
      if (k <= 127) begin
        prod = {64'd0, pu} * {64'd0, f_up};
        pu = prod[125:62];
        exp_rom[128 + k] = q52_to_q16(pu);
      end
      prod = {64'd0, pd} * {64'd0, f_dn};
      pd = prod[125:62];
      exp_rom[128 - k] = q52_to_q16(pd);
    end
  endtask

  // Folds one accepted score into the vector; on the final request, queues
  // one probability per held element and starts a fresh vector.
  task automatic predict_softmax(input logic [ScoreW-1:0] s, input logic fin);
    logic [27:0]  e;
    logic [63:0]  q;
    softmax_out_t r;
    e = exp_rom[{~s[7], s[6:0]}];
    if (held_cnt < HeldMax) begin
      held_e[held_cnt] = e;
      held_sum = held_sum + 34'(e);
      held_cnt++;
    end else begin
      dropped = 1'b1;
    end
    if (fin) begin
      for (int i = 0; i < held_cnt; i++) begin
        if (held_sum == '0) begin
          q = 64'd65535;
        end else begin
          q = (64'(held_e[i]) << 16) / 64'(held_sum);
          if (q > 64'd65535) begin
            q = 64'd65535;
          end
        end
        r.probability = q[15:0];
        r.last_result = (i == held_cnt - 1);
        r.overflowed  = dropped;
        due_probs.push_back(r);
      end
      held_sum = '0;
      held_cnt = 0;
      dropped  = 1'b0;
    end
  endtask

  task automatic queue_score(input logic [ScoreW-1:0] s, input logic fin, input bit drain);
    score_req_t req;
    req.score = s;
    req.fin   = fin;
    req.gap   = 0;
    req.drain = drain;
    queued_scores.push_back(req);
  endtask

  // A vector of random scores, biased a little toward the range ends and the scores around zero.
  task automatic queue_random_vector(input int len, input bit drain);
    logic [ScoreW-1:0] s;
    for (int i = 0; i < len; i++) begin
      case ($urandom_range(0, 7))
        0:       s = 8'h80;
        1:       s = 8'h7F;
        2:       s = ($urandom_range(0, 1) != 0) ? 8'h00 : 8'hFF;
        default: s = 8'($urandom_range(0, 255));
      endcase
      queue_score(s, i == len - 1, drain && (i == 0));
    end
  endtask

  // Driver: presents the queued requests in order, honoring each one's gap
  // and drain mark, and feeds the predictor at every accepted request.
  score_req_t next_req;
  bit         next_loaded;
  int         gap_left;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid      <= 1'b0;
      score         <= '0;
      final_element <= 1'b0;
      next_loaded   = 1'b0;
      gap_left      = 0;
    end else begin
      if (in_valid && in_ready) begin
        predict_softmax(score, final_element);
        accepted_cnt++;
      end
      if (!(in_valid && !in_ready)) begin
        if (!next_loaded && queued_scores.size() != 0) begin
          next_req    = queued_scores.pop_front();
          next_loaded = 1'b1;
          gap_left    = next_req.gap;
        end
        if (next_loaded && gap_left == 0 &&
            !(next_req.drain && due_probs.size() != 0)) begin
          in_valid      <= 1'b1;
          score         <= next_req.score;
          final_element <= next_req.fin;
          next_loaded   = 1'b0;
        end else begin
          if (gap_left > 0) begin
            gap_left--;
          end
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks every accepted result against the oldest expectation and
  // stalls the result channel in bursts whose frequency changes over time.
  int stall_left;
  int stall_pct;
  int rx_cycle;

  always @(posedge clk_i or negedge rst_ni) begin
    softmax_out_t want;
    if (!rst_ni) begin
      out_ready  <= 1'b0;
      stall_left = 0;
      stall_pct  = 0;
      rx_cycle   = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (due_probs.size() == 0) begin
          $display("%0t: unexpected result, probability %0d last %0b overflowed %0b",
                   $time, probability, last_result, overflowed);
          err_cnt++;
        end else begin
          want = due_probs.pop_front();
          if (probability !== want.probability) begin
            $display("%0t: probability mismatch, expected %0d, actual %0d",
                     $time, want.probability, probability);
            err_cnt++;
          end
          if (last_result !== want.last_result) begin
            $display("%0t: last_result mismatch, expected %0b, actual %0b",
                     $time, want.last_result, last_result);
            err_cnt++;
          end
          if (overflowed !== want.overflowed) begin
            $display("%0t: overflowed mismatch, expected %0b, actual %0b",
                     $time, want.overflowed, overflowed);
            err_cnt++;
          end
        end
      end
      if (rx_cycle % 300 == 0) begin
        case ($urandom_range(0, 2))
          0:       stall_pct = 0;
          1:       stall_pct = 15;
          default: stall_pct = 40;
        endcase
      end
      rx_cycle++;
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (queued_scores.size() >= TailLen && $urandom_range(0, 99) < stall_pct) begin
        stall_left = $urandom_range(1, 14) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    fill_exp_rom();
    held_sum     = '0;
    held_cnt     = 0;
    dropped      = 1'b0;
    accepted_cnt = 0;
    err_cnt      = 0;

    // Directed: lone minimum and lone maximum (both saturate), a vector of
    // range ends around zero, two equal scores and alternating bit patterns.
    queue_score(8'h80, 1'b1, 1'b0);
    queue_score(8'h7F, 1'b1, 1'b0);
    queue_score(8'h7F, 1'b0, 1'b1);
    queue_score(8'h80, 1'b0, 1'b0);
    queue_score(8'h00, 1'b0, 1'b0);
    queue_score(8'hFF, 1'b0, 1'b0);
    queue_score(8'h01, 1'b1, 1'b0);
    queue_score(8'h00, 1'b0, 1'b0);
    queue_score(8'h00, 1'b1, 1'b0);
    queue_score(8'h55, 1'b0, 1'b0);
    queue_score(8'hAA, 1'b1, 1'b0);

    // Capacity: exactly full, then one over, then several over.
    queue_random_vector(HeldMax, 1'b0);
    queue_random_vector(HeldMax + 1, 1'b1);
    queue_random_vector(HeldMax + 6, 1'b0);

    // Random vectors, mostly short, now and then near or past capacity.
    while (queued_scores.size() < ItemTarget) begin
      if ($urandom_range(0, 11) == 0) begin
        queue_random_vector($urandom_range(HeldMax - 4, HeldMax + 8),
                            $urandom_range(0, 9) == 0);
      end else begin
        queue_random_vector($urandom_range(1, 12), $urandom_range(0, 9) == 0);
      end
    end

    // Sender gaps: bursts in most stretches, none in every third stretch
    // and none at all in the tail.
    total_reqs = queued_scores.size();
    for (int i = 0; i < total_reqs; i++) begin
      if (i >= total_reqs - TailLen || (i / 40) % 3 == 2) begin
        queued_scores[i].gap = 0;
      end else if ($urandom_range(0, 3) == 0) begin
        queued_scores[i].gap = $urandom_range(1, 14);
      end
    end

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (accepted_cnt < total_reqs) @(posedge clk_i);
    while (due_probs.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #2000000;
    $display("timeout with %0d results still expected", due_probs.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule

>>> files.f
design/smx_pkg.sv
design/smx_store.sv
design/smx_div.sv
design/softmax_vector_engine.sv
sim/tb_softmax_vector_engine.sv
